>>> design/cfd_pkg.sv
package cfd_pkg;

    localparam int unsigned HDR_BYTES  = 7;
    localparam int unsigned MIN_FRAME  = 11;
    localparam int unsigned IDX_W      = 17;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};
    localparam logic [31:0]      CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0]      CRC_ONES  = 32'hFFFF_FFFF;

    typedef logic [IDX_W-1:0] byte_index_t;

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_EXPECTED_VERSION = 1'b0,
        CFG_MAX_PAYLOAD_LEN  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_MALFORMED   = 2'd1,
        STATUS_BAD_VERSION = 2'd2,
        STATUS_BAD_CRC     = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0]  expected_version;
        logic [15:0] max_payload_len;
    } cfd_cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  frame_version;
        logic [15:0] sequence_id;
        logic [15:0] frame_opcode;
        logic [15:0] payload_length;
        logic [31:0] carried_crc;
    } cfd_result_t;

    // one byte of reflected crc-32, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> design/cfd_stream_if.sv
interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface cfd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [7:0]  frame_version;
    logic [15:0] sequence_id;
    logic [15:0] frame_opcode;
    logic [15:0] payload_length;
    logic [31:0] carried_crc;

    modport source (
        output valid, output result_kind, output payload_byte, output status,
        output frame_version, output sequence_id, output frame_opcode,
        output payload_length, output carried_crc, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input status,
        input frame_version, input sequence_id, input frame_opcode,
        input payload_length, input carried_crc, output ready
    );
endinterface

>>> design/cfd_frame_parser.sv
module cfd_frame_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  logic                 last_byte,
    input  cfd_pkg::cfd_cfg_t    cfg,
    output logic                 res_valid,
    output cfd_pkg::cfd_result_t res
);
    import cfd_pkg::*;

    byte_index_t byte_index_reg, byte_index_next;
    logic [31:0] crc_reg, crc_next;
    logic [7:0]  version_reg, version_next;
    logic [15:0] sequence_reg, sequence_next;
    logic [15:0] opcode_reg, opcode_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] trailer_reg, trailer_next;

    logic        in_header;
    logic        in_payload;
    byte_index_t total;
    byte_index_t expect_total;
    status_t     status;

    // per-byte update of the frame state
    always_comb
    begin
        version_next  = version_reg;
        sequence_next = sequence_reg;
        opcode_next   = opcode_reg;
        length_next   = length_reg;
        trailer_next  = trailer_reg;
        crc_next      = crc_reg;

        in_header  = byte_index_reg < byte_index_t'(HDR_BYTES);
        in_payload = !in_header &&
                     (byte_index_reg < (byte_index_t'(HDR_BYTES) + {1'b0, length_reg}));

        if (in_header)
        begin
            case (byte_index_reg[2:0])
                3'd0:    version_next = rx_byte;
                3'd1:    sequence_next[7:0] = rx_byte;
                3'd2:    sequence_next[15:8] = rx_byte;
                3'd3:    opcode_next[7:0] = rx_byte;
                3'd4:    opcode_next[15:8] = rx_byte;
                3'd5:    length_next[7:0] = rx_byte;
                default: length_next[15:8] = rx_byte;
            endcase
        end

        if (in_header || in_payload)
        begin
            crc_next = crc_byte(crc_reg, rx_byte);
        end
        else
        begin
            trailer_next = {rx_byte, trailer_reg[31:8]};
        end
    end

    // end of frame checks, taken on the updated header fields
    always_comb
    begin
        total = (byte_index_reg < INDEX_MAX) ? byte_index_reg + 1'b1 : INDEX_MAX;
        expect_total = byte_index_t'(MIN_FRAME) + {1'b0, length_next};

        if (total < byte_index_t'(MIN_FRAME) || total != expect_total ||
            length_next > cfg.max_payload_len)
        begin
            status = STATUS_MALFORMED;
        end
        else if (version_next != cfg.expected_version)
        begin
            status = STATUS_BAD_VERSION;
        end
        else if ((crc_next ^ CRC_ONES) != trailer_next)
        begin
            status = STATUS_BAD_CRC;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    always_comb
    begin
        res = '0;
        res_valid = accept && (last_byte || in_payload);
        if (last_byte)
        begin
            res.kind           = KIND_END;
            res.status         = status;
            res.frame_version  = version_next;
            res.sequence_id    = sequence_next;
            res.frame_opcode   = opcode_next;
            res.payload_length = length_next;
            res.carried_crc    = trailer_next;
        end
        else
        begin
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = rx_byte;
        end
    end

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (!last_byte && byte_index_reg < INDEX_MAX)
        begin
            byte_index_next = byte_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            crc_reg        <= CRC_ONES;
            version_reg    <= '0;
            sequence_reg   <= '0;
            opcode_reg     <= '0;
            length_reg     <= '0;
            trailer_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                byte_index_reg <= '0;
                crc_reg        <= CRC_ONES;
                version_reg    <= '0;
                sequence_reg   <= '0;
                opcode_reg     <= '0;
                length_reg     <= '0;
                trailer_reg    <= '0;
            end
            else
            begin
                byte_index_reg <= byte_index_next;
                crc_reg        <= crc_next;
                version_reg    <= version_next;
                sequence_reg   <= sequence_next;
                opcode_reg     <= opcode_next;
                length_reg     <= length_next;
                trailer_reg    <= trailer_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> byte_index_reg == '0 && crc_reg == CRC_ONES)
        else $error("frame state not cleared after end of frame");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_byte && byte_index_reg < INDEX_MAX
        |=> byte_index_reg == $past(byte_index_reg) + 1'b1)
        else $error("byte count did not advance");

    a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(byte_index_reg) && $stable(crc_reg))
        else $error("frame state moved without a request");
`endif

endmodule

>>> design/cfd_out_stage.sv
module cfd_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  cfd_pkg::cfd_result_t res,
    output logic                 free,
    cfd_out_if.source            out_ch
);
    import cfd_pkg::*;

    logic        valid_reg, valid_next;
    cfd_result_t data_reg;

    assign free = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.result_kind    = data_reg.kind;
    assign out_ch.payload_byte   = data_reg.payload_byte;
    assign out_ch.status         = data_reg.status;
    assign out_ch.frame_version  = data_reg.frame_version;
    assign out_ch.sequence_id    = data_reg.sequence_id;
    assign out_ch.frame_opcode   = data_reg.frame_opcode;
    assign out_ch.payload_length = data_reg.payload_length;
    assign out_ch.carried_crc    = data_reg.carried_crc;

`ifndef ASSERT_OFF
    a_end_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.kind == KIND_END |-> data_reg.payload_byte == 8'd0)
        else $error("end of frame result carries a payload byte");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.kind == KIND_PAYLOAD
        |-> data_reg.status == STATUS_OK && data_reg.carried_crc == 32'd0)
        else $error("payload result carries frame fields");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result loaded over one still waiting");
`endif

endmodule

>>> design/crc32_frame_decoder_core.sv
// framed packet decoder with crc-32 check
//
// in_ch carries the frame one byte per request, last_byte set on its final
// byte. layout: version, sequence id, opcode, payload length (all
// little-endian), payload, then the little-endian crc-32 of header and
// payload. out_ch gives one request per payload byte as it arrives and one
// end of frame request on the final byte, with header fields, carried crc
// and status (malformed, then version, then crc, else ok). payload goes out
// before the check, so the consumer drops it unless the end status is ok.
//
// latency: a result appears on out_ch the cycle after its byte is taken.
// throughput: one byte per cycle while out_ch is not stalled, set by the
// one-byte crc update between the frame state and the output register.
// stall: a single output register holds the waiting result; in_ch.ready
// stays high while that register is empty or being drained this cycle.
// reset: frame state and output valid clear, expected_version returns to 1
// and max_payload_len to 256. cfg writes land at once, so they belong only
// where no byte is in flight.
module crc32_frame_decoder_core (
    input  logic                  clk,
    input  logic                  rst_n,
    cfd_in_if.sink                in_ch,
    cfd_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  cfd_pkg::cfg_index_t   cfg_index,
    input  logic [cfd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cfd_pkg::*;

    cfd_cfg_t    cfg_reg;
    cfd_result_t res;
    logic        res_valid;
    logic        free;
    logic        accept;

    // a byte is taken whenever the output register can hold what it causes
    assign in_ch.ready = free;
    assign accept      = in_ch.valid && free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version <= 8'd1;
            cfg_reg.max_payload_len  <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_VERSION: cfg_reg.expected_version <= cfg_data[7:0];
                CFG_MAX_PAYLOAD_LEN:  cfg_reg.max_payload_len  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // header capture, crc and trailer tracking, end of frame status
    cfd_frame_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (in_ch.rx_byte),
        .last_byte (in_ch.last_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register towards the consumer
    cfd_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_valid),
        .res    (res),
        .free   (free),
        .out_ch (out_ch)
    );

`ifndef ASSERT_OFF
    a_payload_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.last_byte |=> out_ch.valid && out_ch.result_kind == KIND_END)
        else $error("final byte gave no end of frame result");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !accept)
        else $error("byte taken while result stalled");

    a_cfg_range: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == CFG_EXPECTED_VERSION
        |=> cfg_reg.expected_version == $past(cfg_data[7:0]))
        else $error("version register write lost");
`endif

endmodule
